>>> design/rsc_pkg.sv
// Package for the resizing stack controller: transaction types, codes and
// default sizes shared by the interface, the cells, the controller and the top level.
`timescale 1ns / 1ps

package rsc_pkg;

    // Default sizes
    localparam int RSC_PHYS_DEPTH = 1024;
    localparam int RSC_DATA_BITS  = 32;

    // Fixed field widths
    localparam int SIZE_W  = 11;
    localparam int EVENT_W = 16;
    localparam int VALUE_W = 32;

    // Register reset values
    localparam logic [SIZE_W-1:0] INIT_CAP_RESET = 11'd10;
    localparam logic [SIZE_W-1:0] FLOOR_RESET    = 11'd10;

    // Top value shown when the stack is empty (-99)
    localparam logic signed [VALUE_W-1:0] EMPTY_MARK = -32'sd99;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_INIT_CAP = 1'b0;
    localparam logic CFG_FLOOR    = 1'b1;

    // Source of the top value in a result
    typedef enum logic [1:0] {
        TOP_EMPTY = 2'd0,
        TOP_PUSH  = 2'd1,
        TOP_CELL0 = 2'd2,
        TOP_CELL1 = 2'd3
    } t_top_sel;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic                      index;
        logic        [SIZE_W-1:0]  value;
    } t_cfg;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic                      is_empty;
        logic        [SIZE_W-1:0]  entry_count;
        logic        [SIZE_W-1:0]  capacity;
        logic        [SIZE_W-1:0]  peak_capacity;
        logic        [EVENT_W-1:0] resize_total;
        logic                      push_rejected;
    } t_result;

    // Status fields computed by the controller
    typedef struct packed {
        logic                      is_empty;
        logic        [SIZE_W-1:0]  entry_count;
        logic        [SIZE_W-1:0]  capacity;
        logic        [SIZE_W-1:0]  peak_capacity;
        logic        [EVENT_W-1:0] resize_total;
        logic                      push_rejected;
    } t_status;

    // Shift command for the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

>>> design/rsc_chan_if.sv
// Valid/ready channel used for requests, results and configuration writes.
// The payload type is a parameter; types come from rsc_pkg.
`timescale 1ns / 1ps

interface rsc_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/resizing_stack_controller_unit.sv
// Top level of the resizing stack controller: chain of stack cells, the
// controller and the result skid buffer. Uses rsc_pkg, rsc_chan_if, rsc_cell, rsc_ctrl.
`timescale 1ns / 1ps

// Usage:
//   i_req carries one push or pop per transaction (req_type, push_value).
//   o_rsp returns exactly one result per request: top value (-99 when
//   empty), empty flag, entry count, capacity, peak capacity, resize count
//   and a flag for a push refused because the capacity cannot grow.
//   i_cfg writes register 0 (initial capacity, restarts the stack) or
//   register 1 (shrink floor); it is always ready. The user must use it
//   only while no request is in flight; the block does not enforce this.
//   Each result is registered; one request is taken per cycle while
//   i_req.ready is high. The entries live in a row of PHYS_DEPTH cells that
//   shift down on a push and up on a pop, so the top entry always sits in the
//   first cell and every operation finishes in the cycle it is accepted.
//   Reset (synchronous, active low) empties the stack and loads the default
//   registers; cell contents are not cleared. When the receiver stalls, one
//   further result is held in a skid register, after which i_req.ready
//   drops until the receiver drains.

module resizing_stack_controller_unit
    import rsc_pkg::*;
#(
    parameter int PHYS_DEPTH = RSC_PHYS_DEPTH,
    parameter int DATA_BITS  = RSC_DATA_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsc_chan_if.sink    i_req,
    rsc_chan_if.sink    i_cfg,
    rsc_chan_if.source  o_rsp
);

    // Sign-extend a stored entry and keep the low result bits
    function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_BITS-1:0] d);
        logic [63:0] ext;
        ext = 64'(signed'(d));
        return ext[VALUE_W-1:0];
    endfunction

    t_req     req;
    t_cfg     cfg;
    t_shift   shift;
    t_top_sel top_sel;
    t_status  status;
    t_result  result;
    logic     accept;
    logic     rsp_fire;

    logic [DATA_BITS-1:0] push_data;
    logic [DATA_BITS-1:0] w_cell [PHYS_DEPTH];

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign req         = i_req.data;
    assign cfg         = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;
    assign rsp_fire    = r_out_valid && o_rsp.ready;
    assign push_data   = DATA_BITS'($unsigned(req.push_value));

    // Controller
    rsc_ctrl #(
        .PHYS_DEPTH (PHYS_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg      (cfg),
        .i_accept   (accept),
        .i_req_type (req.req_type),
        .o_shift    (shift),
        .o_top_sel  (top_sel),
        .o_status   (status)
    );

    // Cell chain, first cell holds the top entry
    genvar gi;
    generate
        for (gi = 0; gi < PHYS_DEPTH; gi++) begin : g_cell
            logic [DATA_BITS-1:0] above, below;
            if (gi == 0) begin : g_first
                assign above = push_data;
            end else begin : g_mid
                assign above = w_cell[gi-1];
            end
            if (gi == PHYS_DEPTH - 1) begin : g_last
                assign below = w_cell[gi];
            end else begin : g_inner
                assign below = w_cell[gi+1];
            end
            rsc_cell #(
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_above (above),
                .i_below (below),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

    // Result assembly
    always_comb begin
        case (top_sel)
            TOP_PUSH:  result.top_value = to_value(push_data);
            TOP_CELL0: result.top_value = to_value(w_cell[0]);
            TOP_CELL1: result.top_value = to_value(w_cell[1]);
            default:   result.top_value = EMPTY_MARK;
        endcase
        result.is_empty      = status.is_empty;
        result.entry_count   = status.entry_count;
        result.capacity      = status.capacity;
        result.peak_capacity = status.peak_capacity;
        result.resize_total  = status.resize_total;
        result.push_rejected = status.push_rejected;
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (rsp_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || rsp_fire) begin
                r_out       <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (rsp_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

>>> design/rsc_cell.sv
// One stack cell: holds a single entry and moves it down on a push or up
// on a pop. Depends on rsc_pkg for the shift command.
`timescale 1ns / 1ps

module rsc_cell
    import rsc_pkg::*;
#(
    parameter int DATA_BITS = RSC_DATA_BITS
) (
    input  logic                 i_clk,
    input  t_shift               i_shift,
    input  logic [DATA_BITS-1:0] i_above,
    input  logic [DATA_BITS-1:0] i_below,
    output logic [DATA_BITS-1:0] o_data
);

    logic [DATA_BITS-1:0] r_data;

    // Entry moves one place per transaction
    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_data <= i_above;
        end else if (i_shift.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;

endmodule

>>> design/rsc_ctrl.sv
// Stack controller: entry count, logical capacity with grow/shrink check,
// peak capacity, resize counter and configuration registers. Uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_ctrl
    import rsc_pkg::*;
#(
    parameter int PHYS_DEPTH = RSC_PHYS_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  logic     i_req_type,
    output t_shift   o_shift,
    output t_top_sel o_top_sel,
    output t_status  o_status
);

    localparam int CW = $clog2(PHYS_DEPTH + 1);
    localparam int XW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
    localparam int MW = CW + 6;
    localparam logic [XW-1:0] DEPTH_X = XW'(PHYS_DEPTH);

    // Clamp a capacity value into 1..PHYS_DEPTH
    function automatic logic [CW-1:0] clamp_cap(input logic [SIZE_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (XW'(v) > DEPTH_X) begin
            res = CW'(PHYS_DEPTH);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    logic [SIZE_W-1:0]  r_floor;
    logic [CW-1:0]      r_count, r_cap, r_peak;
    logic [EVENT_W-1:0] r_events;
    logic [CW-1:0]      n_count, n_cap, n_peak;
    logic [EVENT_W-1:0] n_events;

    logic               is_pop, need_grow, grow_fail, do_shrink, do_push, do_pop;
    logic [CW-1:0]      cnt_base, cap_g, cap_s, peak_s;
    logic [CW:0]        grown;
    logic [EVENT_W-1:0] ev_g, ev_s;
    logic [MW-1:0]      lhs, rhs;

    // Resize check and next-state logic for one request
    always_comb begin
        is_pop   = (i_req_type == REQ_POP);
        do_pop   = is_pop && (r_count != '0);
        cnt_base = do_pop ? r_count - CW'(1) : r_count;

        // grow
        need_grow = (cnt_base >= r_cap);
        grown     = {r_cap, 1'b0};
        grow_fail = need_grow && ((CW + 1)'(PHYS_DEPTH) < grown);
        cap_g     = need_grow ? CW'(grown) : r_cap;
        ev_g      = (need_grow && (r_events != '1)) ? r_events + EVENT_W'(1) : r_events;

        // shrink at 15 percent, empty counts as -1
        lhs       = MW'(cnt_base) * MW'(20);
        rhs       = MW'(cap_g) * MW'(3) + MW'(20);
        do_shrink = (XW'(cap_g) > XW'(r_floor)) && (cap_g >= CW'(2)) && (lhs <= rhs);
        cap_s     = do_shrink ? (cap_g >> 1) : cap_g;
        ev_s      = (do_shrink && (ev_g != '1)) ? ev_g + EVENT_W'(1) : ev_g;
        peak_s    = (cap_s > r_peak) ? cap_s : r_peak;

        do_push = !is_pop && !grow_fail && (r_count < CW'(PHYS_DEPTH));

        if (grow_fail) begin
            n_cap    = r_cap;
            n_events = r_events;
            n_peak   = r_peak;
        end else begin
            n_cap    = cap_s;
            n_events = ev_s;
            n_peak   = peak_s;
        end

        if (is_pop) begin
            n_count = cnt_base;
        end else if (do_push) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end

        if (n_count == '0) begin
            o_top_sel = TOP_EMPTY;
        end else if (do_push) begin
            o_top_sel = TOP_PUSH;
        end else if (do_pop) begin
            o_top_sel = TOP_CELL1;
        end else begin
            o_top_sel = TOP_CELL0;
        end
    end

    assign o_shift.push = i_accept && do_push;
    assign o_shift.pop  = i_accept && do_pop;

    assign o_status.is_empty      = (n_count == '0);
    assign o_status.entry_count   = SIZE_W'(n_count);
    assign o_status.capacity      = SIZE_W'(n_cap);
    assign o_status.peak_capacity = SIZE_W'(n_peak);
    assign o_status.resize_total  = n_events;
    assign o_status.push_rejected = !is_pop && !do_push;

    // State registers; writing initial capacity restarts the stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor    <= FLOOR_RESET;
            r_count    <= '0;
            r_cap      <= clamp_cap(INIT_CAP_RESET);
            r_peak     <= clamp_cap(INIT_CAP_RESET);
            r_events   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                CFG_INIT_CAP: begin
                    r_count    <= '0;
                    r_cap      <= clamp_cap(i_cfg.value);
                    r_peak     <= clamp_cap(i_cfg.value);
                    r_events   <= '0;
                end
                CFG_FLOOR: begin
                    r_floor <= i_cfg.value;
                end
                default: begin
                    r_floor <= r_floor;
                end
            endcase
        end else if (i_accept) begin
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_peak   <= n_peak;
            r_events <= n_events;
        end
    end

endmodule

>>> tb/sv/stack_result_checker.sv
// Result checker for the resizing stack controller: watches the request,
// configuration and result channels, predicts each result and compares it.
// Depends on rsc_pkg for the transaction types, codes and sizes.
`timescale 1ns / 1ps

module stack_result_checker
    import rsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_req_ready,
    input  t_req    i_req_data,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  t_cfg    i_cfg_data,
    input  logic    i_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_result i_rsp_data,
    output int      o_fail_count,
    output int      o_outstanding,
    output int      o_results_checked,
    output int      o_refused,
    output logic    o_saturated
);

    // Predicted copy of the stack and its registers
    logic [VALUE_W-1:0] stack_mem [0:RSC_PHYS_DEPTH-1];
    int unsigned depth_held;
    int unsigned cap_now;
    int unsigned cap_peak;
    int unsigned resize_cnt;
    int unsigned init_reg;
    int unsigned floor_reg;

    t_result pending_results [$];
    t_result want;
    t_result predicted;

    int   fail_total      = 0;
    int   results_checked = 0;
    int   refused_total   = 0;
    logic saturated_seen  = 1'b0;

    assign o_fail_count      = fail_total;
    assign o_results_checked = results_checked;
    assign o_refused         = refused_total;
    assign o_saturated       = saturated_seen;

    // Empty the stack and load the clamped initial capacity
    function automatic void restart_stack();
        depth_held = 0;
        if (init_reg == 0) begin
            cap_now = 1;
        end else if (init_reg > RSC_PHYS_DEPTH) begin
            cap_now = RSC_PHYS_DEPTH;
        end else begin
            cap_now = init_reg;
        end
        cap_peak   = cap_now;
        resize_cnt = 0;
    endfunction

    function automatic void count_resize();
        if (resize_cnt < 16'hFFFF) resize_cnt++;
        if (resize_cnt == 16'hFFFF) saturated_seen = 1'b1;
    endfunction

    // Grow then shrink check; 0 when a grow would pass the memory depth
    function automatic bit resize_capacity();
        if (depth_held >= cap_now) begin
            if (cap_now * 2 > RSC_PHYS_DEPTH) return 1'b0;
            cap_now = cap_now * 2;
            count_resize();
        end
        // shrink at 15 percent occupancy, empty counts as -1
        if (cap_now > floor_reg && cap_now >= 2 && 20 * depth_held <= 3 * cap_now + 20) begin
            cap_now = cap_now / 2;
            count_resize();
        end
        if (cap_now > cap_peak) cap_peak = cap_now;
        return 1'b1;
    endfunction

    // Apply one push or pop and build the result it should give
    task automatic predict_stack_op(input t_req req, output t_result res);
        logic refused;
        refused = 1'b0;
        if (req.req_type == REQ_PUSH) begin
            if (resize_capacity() && depth_held < RSC_PHYS_DEPTH) begin
                stack_mem[depth_held] = req.push_value;
                depth_held++;
            end else begin
                refused = 1'b1;
                refused_total++;
            end
        end else begin
            if (depth_held > 0) depth_held--;
            void'(resize_capacity());
        end
        if (depth_held == 0) begin
            res.top_value = EMPTY_MARK;
            res.is_empty  = 1'b1;
        end else begin
            res.top_value = stack_mem[depth_held-1];
            res.is_empty  = 1'b0;
        end
        res.entry_count   = SIZE_W'(depth_held);
        res.capacity      = SIZE_W'(cap_now);
        res.peak_capacity = SIZE_W'(cap_peak);
        res.resize_total  = EVENT_W'(resize_cnt);
        res.push_rejected = refused;
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            if (fail_total < 10) begin
                $display("mismatch in result %0d, %s: expected %0h, got %0h",
                         results_checked, field, exp_val, got_val);
            end
            fail_total++;
        end
    endtask

    // Results are checked before new requests are predicted at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            init_reg  = INIT_CAP_RESET;
            floor_reg = FLOOR_RESET;
            restart_stack();
            pending_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_results.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("unexpected result transaction: top %0h count %0d",
                                 i_rsp_data.top_value, i_rsp_data.entry_count);
                    end
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("top_value", want.top_value, i_rsp_data.top_value);
                    check_field("is_empty", want.is_empty, i_rsp_data.is_empty);
                    check_field("entry_count", want.entry_count, i_rsp_data.entry_count);
                    check_field("capacity", want.capacity, i_rsp_data.capacity);
                    check_field("peak_capacity", want.peak_capacity,
                                i_rsp_data.peak_capacity);
                    check_field("resize_total", want.resize_total,
                                i_rsp_data.resize_total);
                    check_field("push_rejected", want.push_rejected,
                                i_rsp_data.push_rejected);
                end
                results_checked++;
            end
            // register writes only land while the block is idle
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_data.index == CFG_INIT_CAP) begin
                    init_reg = i_cfg_data.value;
                    restart_stack();
                end else begin
                    floor_reg = i_cfg_data.value;
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_stack_op(i_req_data, predicted);
                pending_results.push_back(predicted);
            end
        end
        o_outstanding <= pending_results.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for resizing_stack_controller_unit: clock, reset, stimulus,
// result back-pressure, watchdog and verdict. Uses rsc_pkg, rsc_chan_if and
// stack_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import rsc_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;

    int requests_sent = 0;
    int quiet_cycles  = 0;
    int fail_count;
    int outstanding;
    int results_checked;
    int refused;
    logic saturated;

    rsc_chan_if #(.T(t_req))    req_ch ();
    rsc_chan_if #(.T(t_cfg))    cfg_ch ();
    rsc_chan_if #(.T(t_result)) rsp_ch ();

    resizing_stack_controller_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    stack_result_checker u_result_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_ch.valid),
        .i_req_ready       (req_ch.ready),
        .i_req_data        (req_ch.data),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_data        (cfg_ch.data),
        .i_rsp_valid       (rsp_ch.valid),
        .i_rsp_ready       (rsp_ch.ready),
        .i_rsp_data        (rsp_ch.data),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked),
        .o_refused         (refused),
        .o_saturated       (saturated)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side back-pressure: ready bursts, short stalls and a few long ones
    initial begin
        int unsigned sel;
        int unsigned span;
        logic        lvl;
        rsp_ch.ready <= 1'b0;
        forever begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                lvl  = 1'b1;
                span = $urandom_range(1, 30);
            end else if (sel < 90) begin
                lvl  = 1'b0;
                span = $urandom_range(1, 3);
            end else begin
                lvl  = 1'b0;
                span = $urandom_range(4, 60);
            end
            rsp_ch.ready <= lvl;
            repeat (span) @(posedge clk);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // One request transaction, then a random gap; valid stays up when there is none
    task automatic issue_request(input logic op, input logic [VALUE_W-1:0] value);
        int unsigned sel;
        int unsigned gap;
        req_ch.valid <= 1'b1;
        req_ch.data  <= t_req'{req_type: op, push_value: value};
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        requests_sent++;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            gap = 0;
        end else if (sel < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(4, 40);
        end
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off requests until every predicted result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [SIZE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t_cfg'{index: idx, value: value};
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_capacity_regs(input logic [SIZE_W-1:0] init_cap,
                                     input logic [SIZE_W-1:0] floor_val);
        drain_results();
        write_register(CFG_INIT_CAP, init_cap);
        write_register(CFG_FLOOR, floor_val);
    endtask

    // Random pushes and pops, values biased towards the extremes
    task automatic run_mix(input int n, input int push_pct);
        logic [VALUE_W-1:0] value;
        logic               op;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = EMPTY_MARK;
                3:       value = '0;
                default: value = $urandom();
            endcase
            op = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            issue_request(op, value);
        end
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on empty, extreme values, one grow and one shrink
        issue_request(REQ_POP, 32'hFFFF_FFFF);
        issue_request(REQ_PUSH, 32'h8000_0000);
        issue_request(REQ_PUSH, 32'h7FFF_FFFF);
        issue_request(REQ_PUSH, 32'h0000_0000);
        issue_request(REQ_PUSH, 32'hFFFF_FFFF);
        issue_request(REQ_PUSH, EMPTY_MARK);
        issue_request(REQ_PUSH, 32'hAAAA_AAAA);
        issue_request(REQ_PUSH, 32'h5555_5555);
        for (int k = 0; k < 5; k++) issue_request(REQ_PUSH, $urandom());
        for (int k = 0; k < 13; k++) issue_request(REQ_POP, $urandom());

        // Capacity of one, no shrink floor
        set_capacity_regs(11'd0 + 11'd1, 11'd0);
        run_mix(60, 60);

        // Zero capacity clamps to one; floor at its top, so never halves
        set_capacity_regs(11'd0, 11'd2047);
        run_mix(30, 55);
        drain_results();
        run_mix(30, 55);

        // Oversized capacity clamps to the full depth
        set_capacity_regs(11'd2047, 11'd1);
        run_mix(40, 50);

        // Fill until a grow would pass the memory, then unwind
        set_capacity_regs(11'd513, 11'd16);
        for (int k = 0; k < 525; k++) issue_request(REQ_PUSH, $urandom());
        run_mix(40, 20);

        set_capacity_regs(11'd3, 11'd1024);
        run_mix(60, 55);

        set_capacity_regs(11'd6, 11'd3);
        run_mix(60, 50);

        // Capacity one: alternating pushes and pops grow then halve on every item
        set_capacity_regs(11'd1, 11'd0);
        issue_request(REQ_PUSH, $urandom());
        for (int k = 0; k < 40; k++) begin
            issue_request((k % 2 == 0) ? REQ_PUSH : REQ_POP, $urandom());
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("covered %0d requests over seven register settings, %0d results checked",
                 requests_sent, results_checked);
        $display("%0d pushes refused at full memory, resize count saturated: %0s",
                 refused, saturated ? "yes" : "no");
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
